// ===== rtl/nonpreemptive_priority_scheduler_macros.svh =====
// Assertion helpers shared by the scheduler RTL.
// Both expect signals named clk and rst_n in the enclosing scope.
`ifndef NONPREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define NONPREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NPS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/npsch_pkg.sv =====
package npsch_pkg;

    localparam logic [15:0] CNT_MAX = 16'hFFFF;
    localparam logic [15:0] TURN_MAX = 16'hFFFF;
    localparam logic [31:0] SUM_MAX = 32'hFFFF_FFFF;

    // One tick as it arrives on the input port.
    typedef struct packed {
        logic       arrival_valid;
        logic [7:0] job_id;
        logic [2:0] job_priority;
        logic [3:0] job_service;
    } tick_in_t;

    // One result per tick.
    typedef struct packed {
        logic        running_valid;
        logic [7:0]  running_job;
        logic        arrival_dropped;
        logic        done_res;
        logic [7:0]  done_job;
        logic [2:0]  done_priority;
        logic [15:0] done_wait;
        logic [15:0] done_turnaround;
        logic [15:0] level_count;
        logic [31:0] level_wait_total;
        logic [31:0] level_turn_total;
        logic [31:0] level_response_total;
    } res_out_t;

    // Classified tick handed from the front end to the back end.
    typedef struct packed {
        logic        arrive;
        logic [2:0]  level;
        logic [7:0]  id;
        logic [3:0]  serv;
        logic [15:0] stamp;
    } tick_t;

    // One waiting job in the per-level FIFO memory.
    typedef struct packed {
        logic [15:0] stamp;
        logic [3:0]  serv;
        logic [7:0]  id;
    } entry_t;

endpackage

// ===== rtl/npsch_front.sv =====
module npsch_front
    import npsch_pkg::*;
#(
    parameter int NUM_LEVELS = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     tick_valid,
    output logic     tick_stall,
    input  tick_in_t tick_data,
    output logic     fe_valid,
    input  logic     fe_stall,
    output tick_t    fe_item
);

    logic [15:0] stamp_reg;
    logic [15:0] stamp_next;
    logic        accept;
    logic        in_range;

    assign tick_stall = fe_stall;
    assign fe_valid   = tick_valid;
    assign accept     = tick_valid && !tick_stall;

    // Levels outside 1..NUM_LEVELS are ignored, not dropped.
    always_comb
    begin
        in_range = (tick_data.job_priority != 3'd0)
            && ({1'b0, tick_data.job_priority} <= 4'(NUM_LEVELS));
        fe_item.arrive = tick_data.arrival_valid && in_range;
        fe_item.level  = fe_item.arrive ? (tick_data.job_priority - 3'd1) : 3'd0;
        fe_item.id     = tick_data.job_id;
        fe_item.serv   = (tick_data.job_service == 4'd0) ? 4'd1 : tick_data.job_service;
        fe_item.stamp  = stamp_reg;
        stamp_next     = accept ? (stamp_reg + 16'd1) : stamp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_reg <= '0;
        end
        else
        begin
            stamp_reg <= stamp_next;
        end
    end

endmodule

// ===== rtl/npsch_tickq.sv =====
module npsch_tickq
    import npsch_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  tick_t in_item,
    output logic  out_valid,
    input  logic  out_stall,
    output tick_t out_item
);

    tick_t       slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        pop;

    assign in_stall  = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && !in_stall;
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/npsch_back.sv =====
module npsch_back
    import npsch_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32,
    parameter int NUM_LEVELS  = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_valid,
    output logic     q_stall,
    input  tick_t    q_item,
    output logic     res_valid,
    input  logic     res_stall,
    output res_out_t res_data
);

    localparam int SLOT_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int LVL_W     = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int MEM_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    localparam logic ST_RUN  = 1'b0;
    localparam logic ST_LOAD = 1'b1;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] p);
        logic [SLOT_W-1:0] r;
        r = (p == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : (p + SLOT_W'(1));
        return r;
    endfunction

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? SUM_MAX : s[31:0];
    endfunction

    // FIFO memory and its registered read port
    entry_t            mem [MEM_DEPTH];
    entry_t            mem_rdata_reg;

    logic              state_reg;
    logic              state_next;

    logic [SLOT_W-1:0] head_reg [NUM_LEVELS];
    logic [SLOT_W-1:0] head_next [NUM_LEVELS];
    logic [SLOT_W-1:0] tail_reg [NUM_LEVELS];
    logic [SLOT_W-1:0] tail_next [NUM_LEVELS];
    logic [FILL_W-1:0] fill_reg [NUM_LEVELS];
    logic [FILL_W-1:0] fill_next [NUM_LEVELS];

    logic [15:0]       cnt_reg [NUM_LEVELS];
    logic [15:0]       cnt_next [NUM_LEVELS];
    logic [31:0]       wsum_reg [NUM_LEVELS];
    logic [31:0]       wsum_next [NUM_LEVELS];
    logic [31:0]       tsum_reg [NUM_LEVELS];
    logic [31:0]       tsum_next [NUM_LEVELS];
    logic [31:0]       rsum_reg [NUM_LEVELS];
    logic [31:0]       rsum_next [NUM_LEVELS];

    logic              busy_reg;
    logic              busy_next;
    logic [7:0]        cur_job_reg;
    logic [3:0]        cur_serv_reg;
    logic [3:0]        cur_rem_reg;
    logic [LVL_W-1:0]  cur_lvl_reg;
    logic [15:0]       cur_wait_reg;

    logic [15:0]       hold_stamp_reg;
    logic              drop_hold_reg;
    logic [LVL_W-1:0]  ld_lvl_reg;

    logic              res_valid_reg;
    logic              res_valid_next;
    res_out_t          res_data_reg;
    res_out_t          res_next;

    logic              out_free;
    logic              take;
    logic [LVL_W-1:0]  alvl;
    logic              full;
    logic              can_push;
    logic              push;
    logic              dropped;
    logic              pick_any;
    logic [LVL_W-1:0]  pick_lvl;
    logic              start;
    logic              bypass;
    logic              need_load;
    logic              fire;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    entry_t            wr_entry;

    logic              st;
    entry_t            st_entry;
    logic [LVL_W-1:0]  st_lvl;
    logic [15:0]       now;
    logic              drop_now;

    logic              e_busy;
    logic [7:0]        e_job;
    logic [3:0]        e_serv;
    logic [3:0]        e_rem;
    logic [LVL_W-1:0]  e_lvl;
    logic [15:0]       e_wait;
    logic [3:0]        rem_dec;
    logic              done;
    logic [16:0]       turn_full;
    logic [15:0]       turn;
    logic [15:0]       cnt_new;
    logic [31:0]       wsum_new;
    logic [31:0]       tsum_new;
    logic [31:0]       rsum_new;

    assign q_stall   = !((state_reg == ST_RUN) && out_free);
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // Enqueue, pick and FIFO pointer update
    always_comb
    begin
        out_free = !res_valid_reg || !res_stall;
        take     = (state_reg == ST_RUN) && q_valid && out_free;
        alvl     = q_item.level[LVL_W-1:0];
        full     = (fill_reg[alvl] == FILL_W'(QUEUE_DEPTH));
        can_push = q_item.arrive && !full;
        push     = take && can_push;
        dropped  = q_item.arrive && full;

        pick_any = 1'b0;
        pick_lvl = '0;
        for (int k = NUM_LEVELS - 1; k >= 0; k--)
        begin
            if ((fill_reg[k] != '0) || (can_push && (alvl == LVL_W'(k))))
            begin
                pick_any = 1'b1;
                pick_lvl = LVL_W'(k);
            end
        end

        start     = take && !busy_reg && pick_any;
        bypass    = can_push && (pick_lvl == alvl) && (fill_reg[pick_lvl] == '0);
        need_load = start && !bypass;
        fire      = (state_reg == ST_LOAD) || (take && !need_load);

        wr_entry.stamp = q_item.stamp;
        wr_entry.serv  = q_item.serv;
        wr_entry.id    = q_item.id;
        wr_addr = ADDR_W'(alvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_reg[alvl]);
        rd_addr = ADDR_W'(pick_lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_reg[pick_lvl]);

        for (int k = 0; k < NUM_LEVELS; k++)
        begin
            tail_next[k] = (push && (alvl == LVL_W'(k))) ? next_slot(tail_reg[k]) : tail_reg[k];
            head_next[k] = (start && (pick_lvl == LVL_W'(k)))
                ? next_slot(head_reg[k]) : head_reg[k];
            fill_next[k] = fill_reg[k] + FILL_W'(push && (alvl == LVL_W'(k)))
                - FILL_W'(start && (pick_lvl == LVL_W'(k)));
        end

        unique case (state_reg)
            ST_RUN:  state_next = need_load ? ST_LOAD : ST_RUN;
            ST_LOAD: state_next = ST_RUN;
            default: state_next = ST_RUN;
        endcase
    end

    // Start source, run for one tick, statistics
    always_comb
    begin
        if (state_reg == ST_LOAD)
        begin
            st       = 1'b1;
            st_entry = mem_rdata_reg;
            st_lvl   = ld_lvl_reg;
            now      = hold_stamp_reg;
            drop_now = drop_hold_reg;
        end
        else
        begin
            st       = start && bypass;
            st_entry = wr_entry;
            st_lvl   = pick_lvl;
            now      = q_item.stamp;
            drop_now = dropped;
        end

        e_busy  = busy_reg || st;
        e_job   = st ? st_entry.id : cur_job_reg;
        e_serv  = st ? st_entry.serv : cur_serv_reg;
        e_rem   = st ? st_entry.serv : cur_rem_reg;
        e_lvl   = st ? st_lvl : cur_lvl_reg;
        e_wait  = st ? (now - st_entry.stamp) : cur_wait_reg;
        rem_dec = e_rem - 4'd1;
        done    = e_busy && (rem_dec == 4'd0);

        turn_full = {1'b0, e_wait} + 17'(e_serv);
        turn      = turn_full[16] ? TURN_MAX : turn_full[15:0];
        cnt_new   = (cnt_reg[e_lvl] == CNT_MAX) ? CNT_MAX : (cnt_reg[e_lvl] + 16'd1);
        wsum_new  = sat_add32(wsum_reg[e_lvl], {16'd0, e_wait});
        tsum_new  = sat_add32(tsum_reg[e_lvl], {16'd0, turn});
        rsum_new  = sat_add32(rsum_reg[e_lvl], {16'd0, e_wait});

        for (int k = 0; k < NUM_LEVELS; k++)
        begin
            cnt_next[k]  = cnt_reg[k];
            wsum_next[k] = wsum_reg[k];
            tsum_next[k] = tsum_reg[k];
            rsum_next[k] = rsum_reg[k];
        end
        if (fire && done)
        begin
            cnt_next[e_lvl]  = cnt_new;
            wsum_next[e_lvl] = wsum_new;
            tsum_next[e_lvl] = tsum_new;
            rsum_next[e_lvl] = rsum_new;
        end

        busy_next = fire ? (e_busy && !done) : busy_reg;

        res_next                 = '0;
        res_next.running_valid   = e_busy;
        res_next.running_job     = e_busy ? e_job : 8'd0;
        res_next.arrival_dropped = drop_now;
        if (done)
        begin
            res_next.done_res             = 1'b1;
            res_next.done_job             = e_job;
            res_next.done_priority        = 3'(e_lvl) + 3'd1;
            res_next.done_wait            = e_wait;
            res_next.done_turnaround      = turn;
            res_next.level_count          = cnt_new;
            res_next.level_wait_total     = wsum_new;
            res_next.level_turn_total     = tsum_new;
            res_next.level_response_total = rsum_new;
        end

        if (fire)
        begin
            res_valid_next = 1'b1;
        end
        else
        begin
            res_valid_next = out_free ? 1'b0 : res_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (need_load)
        begin
            mem_rdata_reg  <= mem[rd_addr];
            hold_stamp_reg <= q_item.stamp;
            drop_hold_reg  <= dropped;
            ld_lvl_reg     <= pick_lvl;
        end
        if (fire && e_busy)
        begin
            cur_job_reg  <= e_job;
            cur_serv_reg <= e_serv;
            cur_rem_reg  <= rem_dec;
            cur_lvl_reg  <= e_lvl;
            cur_wait_reg <= e_wait;
        end
        if (fire)
        begin
            res_data_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            busy_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_LEVELS; k++)
            begin
                head_reg[k] <= '0;
                tail_reg[k] <= '0;
                fill_reg[k] <= '0;
                cnt_reg[k]  <= '0;
                wsum_reg[k] <= '0;
                tsum_reg[k] <= '0;
                rsum_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            res_valid_reg <= res_valid_next;
            for (int k = 0; k < NUM_LEVELS; k++)
            begin
                head_reg[k] <= head_next[k];
                tail_reg[k] <= tail_next[k];
                fill_reg[k] <= fill_next[k];
                cnt_reg[k]  <= cnt_next[k];
                wsum_reg[k] <= wsum_next[k];
                tsum_reg[k] <= tsum_next[k];
                rsum_reg[k] <= rsum_next[k];
            end
        end
    end

endmodule

// ===== rtl/nonpreemptive_priority_scheduler.sv =====
// Path: a tick transaction passes the tick queue and output register to its result,
// plus one registered job memory read when an idle processor starts a waiting job.
// Throughput: one tick per cycle while the result is not stalled; a tick that starts
// a stored job also holds the back end in ST_LOAD: the job memory has one read port.
// Reset: rst_n clears counters, pointers, fills, statistics and handshakes at once;
// the job memory is not cleared and needs no clearing pass.
`include "nonpreemptive_priority_scheduler_macros.svh"

module nonpreemptive_priority_scheduler
    import npsch_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32,
    parameter int NUM_LEVELS  = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     tick_valid,
    output logic     tick_stall,
    input  tick_in_t tick_data,
    output logic     res_valid,
    input  logic     res_stall,
    output res_out_t res_data
);

    // Front end to tick queue
    logic  fe_valid;
    logic  fe_stall;
    tick_t fe_item;

    // Tick queue to back end
    logic  q_valid;
    logic  q_stall;
    tick_t q_item;

    // Stamp each tick transaction with the tick counter, decode its level and
    // fix a zero service time up to one tick.
    npsch_front #(
        .NUM_LEVELS (NUM_LEVELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .tick_data  (tick_data),
        .fe_valid   (fe_valid),
        .fe_stall   (fe_stall),
        .fe_item    (fe_item)
    );

    // Two-entry queue: lets the front end keep accepting while the back end
    // waits on a memory read or on a stalled result.
    npsch_tickq u_tickq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fe_valid),
        .in_stall  (fe_stall),
        .in_item   (fe_item),
        .out_valid (q_valid),
        .out_stall (q_stall),
        .out_item  (q_item)
    );

    // Enqueue into the per-level FIFOs, start the lowest-numbered non-empty level when
    // idle, run the current job for one tick and update the level statistics.
    // The result goes to an output register; a stalled result holds the back
    // end, and the front end stalls once the tick queue has filled up.
    npsch_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_LEVELS  (NUM_LEVELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_stall   (q_stall),
        .q_item    (q_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    // A tick with no arriving job, or with level zero, must not classify as an arrival.
    `NPS_ASSERT_SAME(fe_range_chk, tick_valid && (!tick_data.arrival_valid || tick_data.job_priority == 3'd0), !fe_item.arrive, "out-of-range or absent job classified as arrival")

    // Service time entering the queue is never zero.
    `NPS_ASSERT_SAME(fe_serv_chk, fe_valid, fe_item.serv != 4'd0, "zero service time passed to back end")

    // A completion belongs to the job that ran in that tick.
    `NPS_ASSERT_SAME(res_done_chk, res_valid && res_data.done_res, res_data.running_valid && (res_data.running_job == res_data.done_job), "completed job does not match running job")

    // A completion always counts at least one job at its level.
    `NPS_ASSERT_SAME(res_count_chk, res_valid && res_data.done_res, res_data.level_count != 16'd0, "completion with zero level count")

endmodule

// ===== verif/nonpreemptive_priority_scheduler_tb.sv =====
module nonpreemptive_priority_scheduler_tb;
    import npsch_pkg::*;

    localparam int QUEUE_DEPTH = 32;
    localparam int NUM_LEVELS  = 4;
    localparam int IDLE_PCT    = 37;
    localparam int RANDOM_TICKS = 500;
    localparam int SEGMENT_TICKS = 50;
    // Keep one low-priority job waiting behind a stream of level-1 jobs.
    localparam int STARVE_TICKS = 60;
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int SETTLE_CYCLES = 8;

    // Tracks the scheduler state and holds the results owed by the block,
    // oldest first.
    class sched_scoreboard;
        logic [15:0] now_tick;
        entry_t      jobs [NUM_LEVELS][QUEUE_DEPTH];
        int unsigned rd_ptr [NUM_LEVELS];
        int unsigned wr_ptr [NUM_LEVELS];
        int unsigned depth_used [NUM_LEVELS];
        bit          cpu_busy;
        logic [7:0]  cpu_job;
        logic [2:0]  cpu_level;
        logic [3:0]  cpu_left;
        logic [3:0]  cpu_service;
        logic [15:0] cpu_wait;
        logic [15:0] lvl_done [NUM_LEVELS];
        logic [31:0] lvl_wait [NUM_LEVELS];
        logic [31:0] lvl_turn [NUM_LEVELS];
        logic [31:0] lvl_resp [NUM_LEVELS];
        res_out_t    owed_results [$];
        int unsigned faults;

        function new();
            now_tick = '0;
            cpu_busy = 1'b0;
            cpu_job = '0;
            cpu_level = '0;
            cpu_left = '0;
            cpu_service = '0;
            cpu_wait = '0;
            faults = 0;
            for (int k = 0; k < NUM_LEVELS; k++)
            begin
                rd_ptr[k] = 0;
                wr_ptr[k] = 0;
                depth_used[k] = 0;
                lvl_done[k] = '0;
                lvl_wait[k] = '0;
                lvl_turn[k] = '0;
                lvl_resp[k] = '0;
            end
        endfunction

        function logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? SUM_MAX : s[31:0];
        endfunction

        function bit all_clear();
            bit clear;
            clear = !cpu_busy;
            for (int k = 0; k < NUM_LEVELS; k++)
            begin
                if (depth_used[k] != 0)
                    clear = 1'b0;
            end
            return clear;
        endfunction

        // Advance the scheduler by one accepted tick and queue its result.
        function void note_tick(tick_in_t t);
            res_out_t    r;
            int          lv;
            logic [3:0]  serv;
            entry_t      e;
            logic [16:0] turn;
            r = '0;
            if (t.arrival_valid && t.job_priority >= 1 && t.job_priority <= NUM_LEVELS)
            begin
                lv = t.job_priority - 1;
                serv = (t.job_service == 4'd0) ? 4'd1 : t.job_service;
                if (depth_used[lv] >= QUEUE_DEPTH)
                    r.arrival_dropped = 1'b1;
                else
                begin
                    e.stamp = now_tick;
                    e.serv = serv;
                    e.id = t.job_id;
                    jobs[lv][wr_ptr[lv]] = e;
                    wr_ptr[lv] = (wr_ptr[lv] + 1) % QUEUE_DEPTH;
                    depth_used[lv]++;
                end
            end
            if (!cpu_busy)
            begin
                for (int k = 0; k < NUM_LEVELS; k++)
                begin
                    if (depth_used[k] != 0)
                    begin
                        e = jobs[k][rd_ptr[k]];
                        rd_ptr[k] = (rd_ptr[k] + 1) % QUEUE_DEPTH;
                        depth_used[k]--;
                        cpu_busy = 1'b1;
                        cpu_job = e.id;
                        cpu_service = e.serv;
                        cpu_left = e.serv;
                        cpu_level = 3'(k + 1);
                        cpu_wait = now_tick - e.stamp;
                        break;
                    end
                end
            end
            if (cpu_busy)
            begin
                r.running_valid = 1'b1;
                r.running_job = cpu_job;
                cpu_left = cpu_left - 4'd1;
                if (cpu_left == 4'd0)
                begin
                    lv = cpu_level - 1;
                    turn = {1'b0, cpu_wait} + {13'd0, cpu_service};
                    if (turn > {1'b0, TURN_MAX})
                        turn = {1'b0, TURN_MAX};
                    if (lvl_done[lv] != CNT_MAX)
                        lvl_done[lv]++;
                    lvl_wait[lv] = sat_sum(lvl_wait[lv], {16'd0, cpu_wait});
                    lvl_turn[lv] = sat_sum(lvl_turn[lv], {16'd0, turn[15:0]});
                    lvl_resp[lv] = sat_sum(lvl_resp[lv], {16'd0, cpu_wait});
                    cpu_busy = 1'b0;
                    r.done_res = 1'b1;
                    r.done_job = cpu_job;
                    r.done_priority = cpu_level;
                    r.done_wait = cpu_wait;
                    r.done_turnaround = turn[15:0];
                    r.level_count = lvl_done[lv];
                    r.level_wait_total = lvl_wait[lv];
                    r.level_turn_total = lvl_turn[lv];
                    r.level_response_total = lvl_resp[lv];
                end
            end
            now_tick = now_tick + 16'd1;
            owed_results.push_back(r);
        endfunction

        function void report(string what, logic [31:0] want, logic [31:0] got);
            faults++;
            if (faults <= 10)
                $display("mismatch %s: expected %0h, got %0h", what, want, got);
        endfunction

        function void check_field(string what, logic [31:0] want, logic [31:0] got);
            if (want !== got)
                report(what, want, got);
        endfunction

        function void check_result(res_out_t got);
            res_out_t want;
            if (owed_results.size() == 0)
            begin
                report("unexpected result", '0, {31'd0, got.running_valid});
                return;
            end
            want = owed_results.pop_front();
            check_field("running_valid", want.running_valid, got.running_valid);
            check_field("running_job", want.running_job, got.running_job);
            check_field("arrival_dropped", want.arrival_dropped, got.arrival_dropped);
            check_field("done_res", want.done_res, got.done_res);
            check_field("done_job", want.done_job, got.done_job);
            check_field("done_priority", want.done_priority, got.done_priority);
            check_field("done_wait", want.done_wait, got.done_wait);
            check_field("done_turnaround", want.done_turnaround, got.done_turnaround);
            check_field("level_count", want.level_count, got.level_count);
            check_field("level_wait_total", want.level_wait_total, got.level_wait_total);
            check_field("level_turn_total", want.level_turn_total, got.level_turn_total);
            check_field("level_response_total", want.level_response_total,
                        got.level_response_total);
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     tick_valid;
    logic     tick_stall;
    tick_in_t tick_data;
    logic     res_valid;
    logic     res_stall;
    res_out_t res_data;

    // When set, neither side idles: gives a stretch at full rate.
    bit steady;

    sched_scoreboard board;

    nonpreemptive_priority_scheduler #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .NUM_LEVELS (NUM_LEVELS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick_valid(tick_valid),
        .tick_stall(tick_stall),
        .tick_data (tick_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #4 clk = ~clk;
    end

    function automatic tick_in_t make_tick(bit arrive, int id, int prio, int serv);
        tick_in_t t;
        t.arrival_valid = arrive;
        t.job_id = id[7:0];
        t.job_priority = prio[2:0];
        t.job_service = serv[3:0];
        return t;
    endfunction

    // Pick a random tick; density is the chance of an arrival, in percent.
    // About one arrival in twelve carries a level outside 1..NUM_LEVELS.
    function automatic tick_in_t random_tick(int density);
        int prio;
        if ($urandom_range(11) == 0)
        begin
            prio = $urandom_range(3);
            if (prio != 0)
                prio = prio + NUM_LEVELS;
        end
        else
            prio = $urandom_range(NUM_LEVELS, 1);
        return make_tick($urandom_range(99) < density, $urandom_range(255), prio,
                         $urandom_range(15));
    endfunction

    // Offer one tick transaction, hold it until accepted, then record it.
    // Idle cycles go in before valid rises, never while a transaction waits.
    task automatic send_tick(input tick_in_t t);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            tick_valid <= 1'b0;
            @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick_data <= t;
        @(posedge clk);
        while (tick_stall)
            @(posedge clk);
        board.note_tick(t);
    endtask

    // Feed empty ticks until no job is running or waiting.
    task automatic flush_queues();
        while (!board.all_clear())
            send_tick(random_tick(0));
    endtask

    // Hold off the sender until every owed result has come out.
    task automatic wait_results();
        tick_valid <= 1'b0;
        @(posedge clk);
        while (board.owed_results.size() != 0)
            @(posedge clk);
    endtask

    // Result side: check each accepted transaction, then pick the next stall.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            board.check_result(res_data);
        res_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end

    // Give up if the run hangs.
    initial
    begin
        repeat (CYCLE_LIMIT)
            @(posedge clk);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int density;
        board = new();
        steady <= 1'b0;
        rst_n <= 1'b0;
        tick_valid <= 1'b0;
        tick_data <= '0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks: an empty tick with every payload bit set, a long
        // job that holds the processor while jobs at every level queue up,
        // zero service, extreme ids and levels outside the legal range.
        send_tick(make_tick(0, 8'hFF, 7, 15));
        send_tick(make_tick(1, 8'h00, 2, 15));
        send_tick(make_tick(1, 8'h44, 4, 1));
        send_tick(make_tick(1, 8'h33, 3, 0));
        send_tick(make_tick(1, 8'hFF, 1, 2));
        send_tick(make_tick(1, 8'h09, 0, 3));
        send_tick(make_tick(1, 8'h0A, 5, 3));
        send_tick(make_tick(1, 8'h0B, 7, 4));
        send_tick(make_tick(1, 8'h01, 1, 1));
        send_tick(make_tick(1, 8'h02, 2, 3));
        flush_queues();
        wait_results();

        // Random ticks in segments of varying load: heavy segments overflow
        // the FIFOs and drop arrivals, light ones let them drain. Run part
        // of it with no idling on either side.
        for (int seg = 0; seg < RANDOM_TICKS / SEGMENT_TICKS; seg++)
        begin
            density = $urandom_range(100, 10);
            steady <= (seg >= 6 && seg < 10);
            repeat (SEGMENT_TICKS)
                send_tick(random_tick(density));
        end
        steady <= 1'b0;
        flush_queues();
        wait_results();

        // Hold a level-4 job back behind a continuous stream of one-tick
        // level-1 jobs; it starts only once the stream ends and carries a
        // long wait into its turnaround.
        send_tick(make_tick(1, 8'hA0, 1, 2));
        send_tick(make_tick(1, 8'hC4, 4, 15));
        repeat (STARVE_TICKS)
            send_tick(make_tick(1, $urandom_range(255), 1, 1));
        flush_queues();

        wait_results();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (board.owed_results.size() != 0)
            board.report("results never seen", board.owed_results.size(), 0);

        if (board.faults == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
